// File: rtl/swb_pkg.sv
// shared types and constants for the sprite window byte stream
package swb_pkg;

    localparam logic [6:0] MAX_WIDTH      = 7'd96;
    localparam logic [6:0] MAX_HEIGHT     = 7'd64;
    localparam logic [7:0] CMD_SET_COLUMN = 8'h15;
    localparam logic [7:0] CMD_SET_ROW    = 8'h75;
    localparam logic [7:0] COLUMN_END_RST = 8'd96;
    localparam logic [7:0] ROW_END_RST    = 8'd64;

    localparam logic CFG_COLUMN_END = 1'b0;
    localparam logic CFG_ROW_END    = 1'b1;

    typedef enum logic [3:0] {
        ST_COL_CMD,
        ST_COL_X,
        ST_COL_END,
        ST_ROW_CMD,
        ST_ROW_Y,
        ST_ROW_END,
        ST_PIX_HI,
        ST_PIX_LO,
        ST_TCOL_CMD,
        ST_TCOL_X,
        ST_TCOL_END,
        ST_TROW_CMD,
        ST_TROW_Y,
        ST_TROW_END
    } step_t;

    typedef struct packed {
        logic        open;
        logic        pixel;
        logic        tail;
        logic        last;
        logic [7:0]  wx;
        logic [7:0]  row_open;
        logic [7:0]  row_tail;
        logic [15:0] word;
    } job_t;

    typedef struct packed {
        logic column_end_we;
        logic row_end_we;
    } cfg_ctl_t;

endpackage

// File: rtl/swb_in_if.sv
// sprite pixel word channel
interface swb_in_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic        draw;
    logic [7:0]  origin_x;
    logic [7:0]  origin_y;
    logic [6:0]  width;
    logic [6:0]  height;
    logic [15:0] pixel;

    modport source (output valid, start_req, draw, origin_x, origin_y, width, height, pixel,
                    input ready);
    modport sink   (input valid, start_req, draw, origin_x, origin_y, width, height, pixel,
                    output ready);
endinterface

// File: rtl/swb_out_if.sv
// controller byte channel
interface swb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       end_of_sprite;

    modport source (output valid, out_byte, is_data, end_of_sprite, input ready);
    modport sink   (input valid, out_byte, is_data, end_of_sprite, output ready);
endinterface

// File: rtl/swb_front.sv
// front end: tracks sprite position and turns each pixel word into a byte job
module swb_front (
    input  logic          clk,
    input  logic          rst_n,
    swb_in_if.sink        sprite,
    input  logic          full,
    output logic          push,
    output swb_pkg::job_t job
);
    import swb_pkg::*;

    logic        active_reg, active_next;
    logic [6:0]  cc_reg, cc_next;
    logic [6:0]  rc_reg, rc_next;
    logic [7:0]  wx_reg, wy_reg;
    logic [6:0]  sw_reg, sh_reg;
    logic        dm_reg;
    logic [15:0] fp_reg;

    logic        accept;
    logic        start;
    logic        empty_sprite;
    logic [6:0]  w_sat, h_sat;
    logic [7:0]  cur_wx, cur_wy;
    logic [6:0]  cur_sw, cur_sh, cur_cc, cur_rc;
    logic        cur_dm;
    logic [15:0] cur_fp;
    logic [6:0]  cc_inc, rc_inc;
    logic        row_done, finished;

    assign sprite.ready = !full;
    assign accept       = sprite.valid && sprite.ready;
    assign start        = sprite.start_req;

    always_comb
    begin
        w_sat  = (sprite.width > MAX_WIDTH) ? MAX_WIDTH : sprite.width;
        h_sat  = (sprite.height > MAX_HEIGHT) ? MAX_HEIGHT : sprite.height;
        cur_wx = start ? sprite.origin_x : wx_reg;
        cur_wy = start ? sprite.origin_y : wy_reg;
        cur_sw = start ? w_sat : sw_reg;
        cur_sh = start ? h_sat : sh_reg;
        cur_dm = start ? sprite.draw : dm_reg;
        cur_fp = start ? sprite.pixel : fp_reg;
        cur_cc = start ? 7'd0 : cc_reg;
        cur_rc = start ? 7'd0 : rc_reg;

        empty_sprite = start && (w_sat == 7'd0 || h_sat == 7'd0);
        cc_inc   = cur_cc + 7'd1;
        rc_inc   = cur_rc + 7'd1;
        row_done = cc_inc >= cur_sw;
        finished = row_done && (rc_inc >= cur_sh);

        push = accept && (start || active_reg);

        job.open     = start;
        job.pixel    = !empty_sprite;
        job.tail     = !empty_sprite && row_done;
        job.last     = empty_sprite || finished;
        job.wx       = cur_wx;
        job.row_open = cur_wy;
        job.row_tail = cur_wy + {1'b0, rc_inc};
        job.word     = cur_dm ? sprite.pixel : cur_fp;

        active_next = !(empty_sprite || finished);
        cc_next     = row_done ? 7'd0 : cc_inc;
        rc_next     = row_done ? rc_inc : cur_rc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cc_reg     <= '0;
            rc_reg     <= '0;
            wx_reg     <= '0;
            wy_reg     <= '0;
            sw_reg     <= '0;
            sh_reg     <= '0;
            dm_reg     <= 1'b0;
            fp_reg     <= '0;
        end
        else if (push)
        begin
            active_reg <= active_next;
            cc_reg     <= cc_next;
            rc_reg     <= rc_next;
            wx_reg     <= cur_wx;
            wy_reg     <= cur_wy;
            sw_reg     <= cur_sw;
            sh_reg     <= cur_sh;
            dm_reg     <= cur_dm;
            fp_reg     <= cur_fp;
        end
    end

`ifndef ASSERT_OFF
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push && empty_sprite |=> !active_reg)
        else $error("empty sprite left block active");
    a_cc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> cc_reg < sw_reg)
        else $error("column count past sprite width");
    a_start_job: assert property (@(posedge clk) disable iff (!rst_n)
        push && !start |-> !job.open)
        else $error("window job without start");
`endif
endmodule

// File: rtl/swb_queue.sv
// two-entry job queue between front and back
module swb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  swb_pkg::job_t push_job,
    input  logic          pop,
    output swb_pkg::job_t head,
    output logic          empty,
    output logic          full
);
    import swb_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = count_reg == 2'd0;
    assign full  = count_reg == 2'd2;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif
endmodule

// File: rtl/swb_back.sv
// back end: walks each job, registering one controller byte per cycle unless stalled
module swb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  swb_pkg::job_t head,
    input  logic          empty,
    input  logic [7:0]    column_end,
    input  logic [7:0]    row_end,
    output logic          pop,
    swb_out_if.source     stream
);
    import swb_pkg::*;

    step_t      step_reg, step_next;
    logic       busy_reg, busy_next;
    logic       ov_reg;
    logic [7:0] byte_reg;
    logic       data_reg;
    logic       end_reg;

    step_t      cur_step;
    step_t      first_step;
    logic       load;
    logic       last_step;
    logic [7:0] byte_sel;
    logic       data_sel;

    assign stream.valid         = ov_reg;
    assign stream.out_byte      = byte_reg;
    assign stream.is_data       = data_reg;
    assign stream.end_of_sprite = end_reg;

    always_comb
    begin
        if (head.open)
        begin
            first_step = ST_COL_CMD;
        end
        else if (head.pixel)
        begin
            first_step = ST_PIX_HI;
        end
        else
        begin
            first_step = ST_TCOL_CMD;
        end
        cur_step  = busy_reg ? step_reg : first_step;
        load      = !empty && (!ov_reg || stream.ready);
        last_step = 1'b0;
        data_sel  = 1'b0;
        step_next = step_reg;
        busy_next = busy_reg;
        case (cur_step)
            ST_COL_CMD:  begin byte_sel = CMD_SET_COLUMN; step_next = ST_COL_X;    end
            ST_COL_X:    begin byte_sel = head.wx;        step_next = ST_COL_END;  end
            ST_COL_END:  begin byte_sel = column_end;     step_next = ST_ROW_CMD;  end
            ST_ROW_CMD:  begin byte_sel = CMD_SET_ROW;    step_next = ST_ROW_Y;    end
            ST_ROW_Y:    begin byte_sel = head.row_open;  step_next = ST_ROW_END;  end
            ST_ROW_END:
            begin
                byte_sel  = row_end;
                step_next = head.pixel ? ST_PIX_HI : ST_TCOL_CMD;
                last_step = !head.pixel && !head.tail;
            end
            ST_PIX_HI:
            begin
                byte_sel  = head.word[15:8];
                data_sel  = 1'b1;
                step_next = ST_PIX_LO;
            end
            ST_PIX_LO:
            begin
                byte_sel  = head.word[7:0];
                data_sel  = 1'b1;
                step_next = ST_TCOL_CMD;
                last_step = !head.tail;
            end
            ST_TCOL_CMD: begin byte_sel = CMD_SET_COLUMN; step_next = ST_TCOL_X;   end
            ST_TCOL_X:   begin byte_sel = head.wx;        step_next = ST_TCOL_END; end
            ST_TCOL_END: begin byte_sel = column_end;     step_next = ST_TROW_CMD; end
            ST_TROW_CMD: begin byte_sel = CMD_SET_ROW;    step_next = ST_TROW_Y;   end
            ST_TROW_Y:   begin byte_sel = head.row_tail;  step_next = ST_TROW_END; end
            ST_TROW_END:
            begin
                byte_sel  = row_end;
                step_next = ST_COL_CMD;
                last_step = 1'b1;
            end
            default:
            begin
                byte_sel  = row_end;
                step_next = ST_COL_CMD;
                last_step = 1'b1;
            end
        endcase
        if (load)
        begin
            busy_next = !last_step;
        end
        else
        begin
            step_next = step_reg;
        end
        pop = load && last_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_COL_CMD;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (stream.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_sel;
            data_reg <= data_sel;
            end_reg  <= last_step && head.last;
        end
    end

`ifndef ASSERT_OFF
    a_end_is_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && end_reg |-> !data_reg)
        else $error("sprite end on a data word");
    a_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && end_reg |-> byte_reg == row_end)
        else $error("sprite end not on row end argument");
    a_pop_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !busy_reg)
        else $error("job sequencer busy after pop");
`endif
endmodule

// File: rtl/sprite_window_byte_stream.sv
// top level of the sprite window byte stream
// Takes one 16-bit pixel word per input word and emits the controller byte stream at
// one byte per clock unless the output stalls. A start word opens with six window
// bytes (set-column, x, column end, set-row, y, row end); every pixel adds its high
// and low data bytes, and the last pixel of a row adds six more window bytes, so one
// input word gives 2, 6, 8 or 14 output words. Input words are taken every cycle
// while the two-entry job queue has room; the sustained rate is set by the byte
// sequencer in the back end, one output word per cycle unless the output stalls.
// Config writes go to the column end and row end registers and apply to later bytes.
module sprite_window_byte_stream (
    input  logic      clk,
    input  logic      rst_n,
    swb_in_if.sink    sprite,
    swb_out_if.source stream,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data
);
    import swb_pkg::*;

    logic [7:0] column_end_reg;
    logic [7:0] row_end_reg;
    cfg_ctl_t   cfg_ctl;
    job_t       push_job;
    job_t       head;
    logic       push;
    logic       pop;
    logic       empty;
    logic       full;

    always_comb
    begin
        cfg_ctl.column_end_we = cfg_we && (cfg_index == CFG_COLUMN_END);
        cfg_ctl.row_end_we    = cfg_we && (cfg_index == CFG_ROW_END);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_end_reg <= COLUMN_END_RST;
            row_end_reg    <= ROW_END_RST;
        end
        else
        begin
            if (cfg_ctl.column_end_we)
            begin
                column_end_reg <= cfg_data;
            end
            if (cfg_ctl.row_end_we)
            begin
                row_end_reg <= cfg_data;
            end
        end
    end

    swb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sprite (sprite),
        .full   (full),
        .push   (push),
        .job    (push_job)
    );

    swb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    swb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .column_end (column_end_reg),
        .row_end    (row_end_reg),
        .pop        (pop),
        .stream     (stream)
    );
endmodule
